/* src/rgd_pkg.sv */
// Shared types and constants for the RAW10 gray downscaler.
package rgd_pkg;

    localparam int CFG_W = 13;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_TARGET_WIDTH  = 2'd2;
    localparam logic [1:0] REG_TARGET_HEIGHT = 2'd3;

    localparam logic [CFG_W-1:0] SOURCE_WIDTH_RST  = 13'd1920;
    localparam logic [CFG_W-1:0] SOURCE_HEIGHT_RST = 13'd1080;
    localparam logic [CFG_W-1:0] TARGET_WIDTH_RST  = 13'd240;
    localparam logic [CFG_W-1:0] TARGET_HEIGHT_RST = 13'd320;

    typedef struct packed {
        logic [7:0] pixel0_msb;
        logic [7:0] pixel1_msb;
        logic [7:0] pixel2_msb;
        logic [7:0] pixel3_msb;
        logic [7:0] low_bits_byte;
    } in_beat_t;

    typedef struct packed {
        logic [15:0] pixel_rgb565;
        logic [11:0] out_column;
        logic [11:0] out_row;
        logic        row_end;
        logic        frame_end;
        logic        run_last;
    } out_beat_t;

endpackage

/* src/raw10_gray_downscale_to_rgb565.sv */
// Nearest-neighbor downscaler from packed RAW10 groups to gray RGB565 pixels.
//
// Usage:
//   src_valid/src_ready/src_data take one RAW10 group (four high bytes and a
//   byte of low bit pairs) per beat, in raster order over the source frame.
//   dst_valid/dst_ready/dst_data give one gray RGB565 pixel per beat with its
//   destination column and row, row and frame end marks, and run_last on the
//   last pixel that a group produced.
//   The APB port holds source and target width and height; write it only
//   while no group is in flight.
// Timing:
//   The pixel stepper handles one pixel of the held group per cycle while
//   the pending and output registers have room, and the next group is taken
//   in the cycle of the fourth pixel.
//   A kept pixel waits in a pending register until the next kept pixel or
//   the end of its group settles run_last, then moves to the output register.
// Reset clears all positions and accumulators and loads the default frame
// size. A stalled receiver holds the output register; the pending register
// then fills and the stepper stops on the next kept pixel.
module raw10_gray_downscale_to_rgb565 #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     src_valid,
    output logic                     src_ready,
    input  rgd_pkg::in_beat_t        src_data,
    output logic                     dst_valid,
    input  logic                     dst_ready,
    output rgd_pkg::out_beat_t       dst_data,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [rgd_pkg::ADDR_W-1:0] paddr,
    input  logic [rgd_pkg::DATA_W-1:0] pwdata,
    output logic [rgd_pkg::DATA_W-1:0] prdata,
    output logic                     pready
);

    localparam int CFG_MAX = (1 << rgd_pkg::CFG_W) - 1;
    localparam int EFF_MAX = (MAX_DIMENSION < CFG_MAX) ? MAX_DIMENSION : CFG_MAX;
    localparam int DIM_W = $clog2(EFF_MAX + 1);
    localparam int AW = 2 * DIM_W;

    // configuration registers
    logic [rgd_pkg::CFG_W-1:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    logic                      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= rgd_pkg::SOURCE_WIDTH_RST;
            src_h_reg <= rgd_pkg::SOURCE_HEIGHT_RST;
            dst_w_reg <= rgd_pkg::TARGET_WIDTH_RST;
            dst_h_reg <= rgd_pkg::TARGET_HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                rgd_pkg::REG_SOURCE_WIDTH:  src_w_reg <= pwdata[rgd_pkg::CFG_W-1:0];
                rgd_pkg::REG_SOURCE_HEIGHT: src_h_reg <= pwdata[rgd_pkg::CFG_W-1:0];
                rgd_pkg::REG_TARGET_WIDTH:  dst_w_reg <= pwdata[rgd_pkg::CFG_W-1:0];
                rgd_pkg::REG_TARGET_HEIGHT: dst_h_reg <= pwdata[rgd_pkg::CFG_W-1:0];
                default:                    src_w_reg <= src_w_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            rgd_pkg::REG_SOURCE_WIDTH:  prdata = rgd_pkg::DATA_W'(src_w_reg);
            rgd_pkg::REG_SOURCE_HEIGHT: prdata = rgd_pkg::DATA_W'(src_h_reg);
            rgd_pkg::REG_TARGET_WIDTH:  prdata = rgd_pkg::DATA_W'(dst_w_reg);
            rgd_pkg::REG_TARGET_HEIGHT: prdata = rgd_pkg::DATA_W'(dst_h_reg);
            default:                    prdata = '0;
        endcase
    end

    // zero acts as one, oversize clamps to the maximum
    function automatic logic [DIM_W-1:0] eff_dim(input logic [rgd_pkg::CFG_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (32'(v) > MAX_DIMENSION)
            r = DIM_W'(EFF_MAX);
        else
            r = DIM_W'(v);
        return r;
    endfunction

    logic [DIM_W-1:0] sw, sh, dw, dh;
    assign sw = eff_dim(src_w_reg);
    assign sh = eff_dim(src_h_reg);
    assign dw = eff_dim(dst_w_reg);
    assign dh = eff_dim(dst_h_reg);

    // held group
    rgd_pkg::in_beat_t grp_reg;
    logic              grp_valid_reg, grp_valid_next;
    logic [1:0]        idx_reg, idx_next;

    // scan state
    logic [DIM_W-1:0] scol_reg, scol_next, srow_reg, srow_next;
    logic [DIM_W-1:0] dcol_reg, dcol_next;
    logic [DIM_W:0]   drow_reg, drow_next;
    logic [AW-1:0]    cacc_reg, cacc_next, cbase_reg, cbase_next;
    logic [AW-1:0]    racc_reg, racc_next, rbase_reg, rbase_next;
    logic             rchosen_reg, rchosen_next;

    // pending and output beats
    rgd_pkg::out_beat_t pend_reg, pend_next, dout_reg, dout_next;
    logic               pend_valid_reg, pend_valid_next;
    logic               pend_done_reg, pend_done_next;
    logic               dout_valid_reg, dout_valid_next;

    logic       keep, step, last_pix, out_free, move, drain, accept;
    logic [7:0] gray;
    logic [DIM_W:0] drow_tmp;
    logic [AW-1:0]  rbase_tmp;
    rgd_pkg::out_beat_t new_beat;

    always_comb
    begin
        case (idx_reg)
            2'd0:    gray = grp_reg.pixel0_msb;
            2'd1:    gray = grp_reg.pixel1_msb;
            2'd2:    gray = grp_reg.pixel2_msb;
            default: gray = grp_reg.pixel3_msb;
        endcase
    end

    assign keep = grp_valid_reg && rchosen_reg && (drow_reg < (DIM_W+1)'(dh)) &&
                  (dcol_reg < dw) &&
                  ({1'b0, cbase_reg} < ({1'b0, cacc_reg} + (AW+1)'(dw)));
    assign out_free = !dout_valid_reg || dst_ready;
    assign step     = grp_valid_reg && (!keep || !pend_valid_reg || out_free);
    assign last_pix = (idx_reg == 2'd3);
    assign src_ready = !grp_valid_reg || (step && last_pix);
    assign accept    = src_valid && src_ready;
    assign move      = step && keep && pend_valid_reg;
    assign drain     = !move && pend_valid_reg && pend_done_reg && out_free;

    always_comb
    begin
        new_beat.pixel_rgb565 = {gray[7:3], gray[7:2], gray[7:3]};
        new_beat.out_column   = 12'(dcol_reg);
        new_beat.out_row      = 12'(drow_reg);
        new_beat.row_end      = (dcol_reg == dw - DIM_W'(1));
        new_beat.frame_end    = new_beat.row_end &&
                                (drow_reg == (DIM_W+1)'(dh) - (DIM_W+1)'(1));
        new_beat.run_last     = 1'b0;
    end

    // group register and pixel index
    always_comb
    begin
        grp_valid_next = grp_valid_reg;
        idx_next       = idx_reg;
        if (step)
        begin
            idx_next = idx_reg + 2'd1;
            if (last_pix)
                grp_valid_next = 1'b0;
        end
        if (accept)
        begin
            grp_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
    end

    // one pixel of scan state per step
    always_comb
    begin
        scol_next    = scol_reg;
        srow_next    = srow_reg;
        dcol_next    = dcol_reg;
        drow_next    = drow_reg;
        cacc_next    = cacc_reg;
        cbase_next   = cbase_reg;
        racc_next    = racc_reg;
        rbase_next   = rbase_reg;
        rchosen_next = rchosen_reg;
        drow_tmp     = rchosen_reg ? drow_reg + (DIM_W+1)'(1) : drow_reg;
        rbase_tmp    = rchosen_reg ? rbase_reg + AW'(sh) : rbase_reg;
        if (step)
        begin
            if (keep)
            begin
                dcol_next  = dcol_reg + DIM_W'(1);
                cbase_next = cbase_reg + AW'(sw);
            end
            if (({1'b0, scol_reg} + (DIM_W+1)'(1)) >= (DIM_W+1)'(sw))
            begin
                scol_next  = '0;
                cacc_next  = '0;
                cbase_next = '0;
                dcol_next  = '0;
                if (({1'b0, srow_reg} + (DIM_W+1)'(1)) >= (DIM_W+1)'(sh))
                begin
                    // frame done: back to the reset position
                    srow_next    = '0;
                    drow_next    = '0;
                    racc_next    = '0;
                    rbase_next   = '0;
                    rchosen_next = 1'b1;
                end
                else
                begin
                    srow_next    = srow_reg + DIM_W'(1);
                    racc_next    = racc_reg + AW'(dh);
                    drow_next    = drow_tmp;
                    rbase_next   = rbase_tmp;
                    rchosen_next = (drow_tmp < (DIM_W+1)'(dh)) &&
                                   ({1'b0, rbase_tmp} <
                                    ({1'b0, racc_reg} + (AW+1)'(dh) + (AW+1)'(dh)));
                end
            end
            else
            begin
                scol_next = scol_reg + DIM_W'(1);
                cacc_next = cacc_reg + AW'(dw);
            end
        end
    end

    // pending beat waits until run_last is known
    always_comb
    begin
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        pend_done_next  = pend_done_reg;
        dout_next       = dout_reg;
        dout_valid_next = dout_valid_reg && !dst_ready;
        if (move || drain)
        begin
            dout_next          = pend_reg;
            dout_next.run_last = pend_done_reg;
            dout_valid_next    = 1'b1;
        end
        if (step && keep)
        begin
            pend_next       = new_beat;
            pend_valid_next = 1'b1;
            pend_done_next  = last_pix;
        end
        else
        begin
            if (drain)
                pend_valid_next = 1'b0;
            if (step && last_pix)
                pend_done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            scol_reg       <= '0;
            srow_reg       <= '0;
            dcol_reg       <= '0;
            drow_reg       <= '0;
            cacc_reg       <= '0;
            cbase_reg      <= '0;
            racc_reg       <= '0;
            rbase_reg      <= '0;
            rchosen_reg    <= 1'b1;
            pend_valid_reg <= 1'b0;
            pend_done_reg  <= 1'b0;
            dout_valid_reg <= 1'b0;
        end
        else
        begin
            grp_valid_reg  <= grp_valid_next;
            idx_reg        <= idx_next;
            scol_reg       <= scol_next;
            srow_reg       <= srow_next;
            dcol_reg       <= dcol_next;
            drow_reg       <= drow_next;
            cacc_reg       <= cacc_next;
            cbase_reg      <= cbase_next;
            racc_reg       <= racc_next;
            rbase_reg      <= rbase_next;
            rchosen_reg    <= rchosen_next;
            pend_valid_reg <= pend_valid_next;
            pend_done_reg  <= pend_done_next;
            dout_valid_reg <= dout_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            grp_reg <= src_data;
        pend_reg <= pend_next;
        dout_reg <= dout_next;
    end

    assign dst_valid = dout_valid_reg;
    assign dst_data  = dout_reg;

    a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_data.frame_end |-> dst_data.row_end)
        else $error("frame_end without row_end");

    a_open_pend_has_group: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg && !pend_done_reg |-> grp_valid_reg)
        else $error("open pending beat without a group in work");

    a_accept_starts_group: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && src_ready |=> grp_valid_reg && idx_reg == 2'd0)
        else $error("accepted group not started at first pixel");

    a_step_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        move |-> out_free)
        else $error("pending beat moved into a full output register");

endmodule
